@@ design/rcsh_pkg.sv @@
// Shared constants for the record CRC-32 block with skipped header.
// Used by rcsh_crc_unit and record_crc32_skip_header; depends on nothing.
package rcsh_pkg;

   localparam int unsigned CRC_WIDTH  = 32;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned POS_WIDTH  = 4;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'hEDB88320;
   localparam logic [CRC_WIDTH-1:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic [POS_WIDTH-1:0] POS_MAX          = 4'd15;
   localparam logic [POS_WIDTH-1:0] HEADER_SKIP_INIT = 4'd4;

endpackage

@@ design/rcsh_crc_unit.sv @@
// One-byte update of the reflected CRC-32, built as eight shift/xor steps.
// Depends on rcsh_pkg for the polynomial and widths.
module rcsh_crc_unit (
   input  logic [rcsh_pkg::CRC_WIDTH-1:0]  crc_cur,
   input  logic [rcsh_pkg::BYTE_WIDTH-1:0] data_byte,
   output logic [rcsh_pkg::CRC_WIDTH-1:0]  crc_next
);

   always_comb begin
      logic [rcsh_pkg::CRC_WIDTH-1:0] v;
      v = {{(rcsh_pkg::CRC_WIDTH - rcsh_pkg::BYTE_WIDTH){1'b0}},
           crc_cur[rcsh_pkg::BYTE_WIDTH-1:0] ^ data_byte};
      // Each step folds out one bit; together they replace the 256-entry table.
      for (int k = 0; k < rcsh_pkg::BYTE_WIDTH; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ rcsh_pkg::CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      crc_next = v ^ (crc_cur >> rcsh_pkg::BYTE_WIDTH);
   end

endmodule

@@ design/record_crc32_skip_header.sv @@
// Top level of the record CRC-32 block: input register, CRC update, result register.
// Depends on rcsh_pkg and rcsh_crc_unit.
//
//   port group   direction  beat contents
//   req_*        in         data_byte (8 bits), last_byte (1 bit)
//   rsp_*        out        crc_value (32 bits), one beat per record
//   csr_*        in         header_skip (4 bits), write only
//
// Every request beat is first captured in an input register and processed in the
// following cycle, so beats are taken one per clock, unless a last byte must wait
// there behind a stalled result. A record's result is loaded into the result
// register when its last byte is processed. The byte update is one pass through
// rcsh_crc_unit.
// Reset is synchronous and active high; it restores header_skip to four bytes,
// the running CRC to all ones and the byte position to zero.
// A stalled result holds in the result register; only a last byte then waits in
// the input register, and the request side stalls behind it.
module record_crc32_skip_header (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rcsh_pkg::BYTE_WIDTH-1:0]  req_data_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rcsh_pkg::CRC_WIDTH-1:0]   rsp_crc_value,
   input  logic                             csr_wr_en,
   input  logic [rcsh_pkg::POS_WIDTH-1:0]   csr_wr_data
);

   // Configuration register.
   logic [rcsh_pkg::POS_WIDTH-1:0] header_skip_ff;

   // Input register stage.
   logic                              s1_valid_ff;
   logic [rcsh_pkg::BYTE_WIDTH-1:0]   s1_data_ff;
   logic                              s1_last_ff;

   // Record state.
   logic [rcsh_pkg::CRC_WIDTH-1:0]    running_crc_ff;
   logic [rcsh_pkg::CRC_WIDTH-1:0]    running_crc_in;
   logic [rcsh_pkg::POS_WIDTH-1:0]    byte_position_ff;
   logic [rcsh_pkg::POS_WIDTH-1:0]    byte_position_in;

   // Result register.
   logic                              rsp_valid_ff;
   logic [rcsh_pkg::CRC_WIDTH-1:0]    rsp_crc_ff;

   logic                              out_free;
   logic                              proc_fire;
   logic                              req_fire;
   logic                              include_byte;
   logic [rcsh_pkg::CRC_WIDTH-1:0]    crc_updated;
   logic [rcsh_pkg::CRC_WIDTH-1:0]    crc_after;

   rcsh_crc_unit u_crc (
      .crc_cur   (running_crc_ff),
      .data_byte (s1_data_ff),
      .crc_next  (crc_updated)
   );

   // The result register can take a new result when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A non-last byte never needs the result register, so it always moves on.
   assign proc_fire = s1_valid_ff && (!s1_last_ff || out_free);
   // The input register refills whenever it is empty or its beat moves on.
   assign req_stall = s1_valid_ff && !proc_fire;
   assign req_fire  = req_valid && !req_stall;

   // A byte enters the CRC once the header has gone by; the position saturates.
   assign include_byte = (byte_position_ff >= header_skip_ff);
   assign crc_after    = include_byte ? crc_updated : running_crc_ff;

   always_comb begin
      running_crc_in   = running_crc_ff;
      byte_position_in = byte_position_ff;
      if (proc_fire) begin
         if (s1_last_ff) begin
            running_crc_in   = rcsh_pkg::CRC_ONES;
            byte_position_in = '0;
         end else begin
            running_crc_in = crc_after;
            if (byte_position_ff != rcsh_pkg::POS_MAX) begin
               byte_position_in = byte_position_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff   <= rcsh_pkg::HEADER_SKIP_INIT;
         s1_valid_ff      <= 1'b0;
         running_crc_ff   <= rcsh_pkg::CRC_ONES;
         byte_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            header_skip_ff <= csr_wr_data;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            s1_valid_ff <= 1'b0;
         end
         running_crc_ff   <= running_crc_in;
         byte_position_ff <= byte_position_in;
         if (proc_fire && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (proc_fire && s1_last_ff) begin
         rsp_crc_ff <= crc_after ^ rcsh_pkg::CRC_ONES;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

`ifndef NO_ASSERTIONS
   // Finishing a record returns the state to its start-of-record values.
   a_record_restart: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && s1_last_ff) |=>
         (running_crc_ff == rcsh_pkg::CRC_ONES) && (byte_position_ff == '0))
      else $error("record state not restarted after last byte");

   // A last byte may not leave the input register while a result is held back.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s1_valid_ff && s1_last_ff) |-> !proc_fire)
      else $error("held result would be overwritten");

   // The byte position saturates instead of wrapping inside a long record.
   a_pos_saturate: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && !s1_last_ff && (byte_position_ff == rcsh_pkg::POS_MAX)) |=>
         (byte_position_ff == rcsh_pkg::POS_MAX))
      else $error("byte position wrapped");

   // Stalling the request side only happens with a beat waiting in the input register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked last byte");
`endif

endmodule
